FILE: design/bilinear_plane_scaler_top_assert.svh
// Assertion macros for the bilinear plane scaler checker.
`ifndef BILINEAR_PLANE_SCALER_TOP_ASSERT_SVH
`define BILINEAR_PLANE_SCALER_TOP_ASSERT_SVH

// Check a condition at every rising edge, reset included.
`define BPS_ASSERT_ALWAYS(name, cond, msg) \
	name: assert property (@(posedge clk) (cond)) else $error(msg);

// Implication checked only outside reset.
`define BPS_ASSERT_IMPL(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

FILE: design/bps_pkg.sv
// Shared types, constants and arithmetic helpers of the bilinear plane scaler.
package bps_pkg;

	localparam int FRAC_BITS  = 8;
	localparam int FRAC_ONE   = 1 << FRAC_BITS;
	localparam int FRAC_HALF  = FRAC_ONE / 2;
	localparam int NUM_W      = 30;
	localparam int DEN_W      = 14;
	localparam int REM_W      = 13;
	localparam int DIV_STAGES = NUM_W;
	localparam int QDEPTH     = 4;
	localparam int QPTR_W     = 2;
	localparam int QCNT_W     = 3;

	// Register indexes on the configuration port
	localparam logic [2:0] REG_SRC_WIDTH  = 3'd0;
	localparam logic [2:0] REG_SRC_HEIGHT = 3'd1;
	localparam logic [2:0] REG_DST_WIDTH  = 3'd2;
	localparam logic [2:0] REG_DST_HEIGHT = 3'd3;
	localparam logic [2:0] REG_CHANNELS   = 3'd4;

	// Operation codes
	localparam logic OP_WRITE   = 1'b0;
	localparam logic OP_REQUEST = 1'b1;

	typedef struct packed {
		logic [9:0]  src_width;
		logic [9:0]  src_height;
		logic [12:0] dst_width;
		logic [12:0] dst_height;
		logic [1:0]  channels;
	} cfg_t;

	// One axis of the divider: numerator shifting out, quotient shifting in
	typedef struct packed {
		logic [NUM_W-1:0] nq;
		logic [REM_W-1:0] rem;
		logic [DEN_W-1:0] den;
	} div_lane_t;

	// Side information carried alongside the division
	typedef struct packed {
		logic        is_write;
		logic        pass;
		logic        ch;
		logic [12:0] row;
		logic [12:0] off;
		logic        ok;
		logic [7:0]  sample;
	} info_t;

	// Work item handed from the front to the back
	typedef struct packed {
		logic        is_write;
		logic        pass;
		logic [3:0]  tap_ok;
		logic [12:0] row0;
		logic [12:0] row1;
		logic [12:0] off0;
		logic [12:0] off1;
		logic [7:0]  sample;
		logic [7:0]  fx;
		logic [7:0]  fy;
	} work_t;

	// One restoring division step
	function automatic div_lane_t div_step(input div_lane_t d);
		logic [DEN_W-1:0] trial;
		logic             ge;
		div_lane_t        r;
		trial = {d.rem, d.nq[NUM_W-1]};
		ge = (trial >= d.den);
		r.den = d.den;
		r.rem = ge ? REM_W'(trial - d.den) : trial[REM_W-1:0];
		r.nq = {d.nq[NUM_W-2:0], ge};
		return r;
	endfunction

	// (a*(256-f) + b*f) >> 8
	function automatic logic [7:0] lerp8(input logic [7:0] a, input logic [7:0] b,
		input logic [7:0] f);
		logic [16:0] acc;
		logic [8:0]  nf;
		nf = 9'(FRAC_ONE) - {1'b0, f};
		acc = 17'(a) * 17'(nf) + 17'(b) * 17'(f);
		return acc[15:8];
	endfunction

endpackage

FILE: design/bilinear_plane_scaler_top.sv
// Bilinear plane scaler top level: APB registers, front end, queue, back end.
// An accepted request passes the input register, the divider stages and the queue to the
// back end, which reads its taps and blends them into the result register.
// Back-end use: a write or pass-through takes a single memory access, a resampled
// request four accesses, one per tap on the single frame memory port.
// Reset clears control state and sets registers to defaults; frame memory content is
// undefined until written. Results are strobed for one cycle and cannot be held off.
module bilinear_plane_scaler_top #(
	parameter int MAX_ROW_BYTES = 512,
	parameter int MAX_ROWS      = 512
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        start,
	output logic        busy,
	input  logic        op,
	input  logic [8:0]  src_col,
	input  logic [8:0]  src_row,
	input  logic [11:0] dst_col,
	input  logic [11:0] dst_row,
	input  logic        channel,
	input  logic [7:0]  sample,
	output logic        done,
	output logic [7:0]  pixel
);
	import bps_pkg::*;

	cfg_t       cfg_q;
	logic       wr;
	logic [2:0] reg_idx;
	logic [9:0] v10;
	logic [12:0] v13;
	logic       push, pop, empty, full;
	work_t      work, head;

	assign pready  = 1'b1;
	assign wr      = psel && penable && pwrite;
	assign reg_idx = paddr[4:2];
	assign v10     = pwdata[9:0];
	assign v13     = pwdata[12:0];

	// Register writes, saturated into range
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.src_width  <= 10'd512;
			cfg_q.src_height <= 10'd512;
			cfg_q.dst_width  <= 13'd512;
			cfg_q.dst_height <= 13'd512;
			cfg_q.channels   <= 2'd1;
		end else if (wr) begin
			case (reg_idx)
				REG_SRC_WIDTH: cfg_q.src_width <= (v10 == '0) ? 10'd1 :
					((v10 > 10'd512) ? 10'd512 : v10);
				REG_SRC_HEIGHT: cfg_q.src_height <= (v10 == '0) ? 10'd1 :
					((v10 > 10'd512) ? 10'd512 : v10);
				REG_DST_WIDTH: cfg_q.dst_width <= (v13 == '0) ? 13'd1 :
					((v13 > 13'd4096) ? 13'd4096 : v13);
				REG_DST_HEIGHT: cfg_q.dst_height <= (v13 == '0) ? 13'd1 :
					((v13 > 13'd4096) ? 13'd4096 : v13);
				REG_CHANNELS: cfg_q.channels <= (pwdata[1:0] == 2'd0) ? 2'd1 :
					((pwdata[1:0] == 2'd3) ? 2'd2 : pwdata[1:0]);
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	// Register read-back
	always_comb begin
		case (reg_idx)
			REG_SRC_WIDTH:  prdata = 32'(cfg_q.src_width);
			REG_SRC_HEIGHT: prdata = 32'(cfg_q.src_height);
			REG_DST_WIDTH:  prdata = 32'(cfg_q.dst_width);
			REG_DST_HEIGHT: prdata = 32'(cfg_q.dst_height);
			REG_CHANNELS:   prdata = 32'(cfg_q.channels);
			default:        prdata = '0;
		endcase
	end

	assign busy = full;

	bps_front #(
		.MAX_ROW_BYTES(MAX_ROW_BYTES),
		.MAX_ROWS     (MAX_ROWS)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.start  (start),
		.op     (op),
		.src_col(src_col),
		.src_row(src_row),
		.dst_col(dst_col),
		.dst_row(dst_row),
		.channel(channel),
		.sample (sample),
		.full   (full),
		.push   (push),
		.work   (work)
	);

	bps_fifo u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.din   (work),
		.pop   (pop),
		.dout  (head),
		.empty (empty),
		.full  (full)
	);

	bps_back #(
		.MAX_ROW_BYTES(MAX_ROW_BYTES),
		.MAX_ROWS     (MAX_ROWS)
	) u_back (
		.clk   (clk),
		.arst_n(arst_n),
		.empty (empty),
		.head  (head),
		.pop   (pop),
		.done  (done),
		.pixel (pixel)
	);

endmodule

FILE: design/bps_ram.sv
// Generic single-port RAM with registered read.
module bps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 262144
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

FILE: design/bps_div.sv
// Pipelined restoring divider, one quotient bit per stage, both axes in step.
module bps_div (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  bps_pkg::div_lane_t in_x,
	input  bps_pkg::div_lane_t in_y,
	input  bps_pkg::info_t    in_info,
	output logic              out_valid,
	output bps_pkg::div_lane_t out_x,
	output bps_pkg::div_lane_t out_y,
	output bps_pkg::info_t    out_info
);
	import bps_pkg::*;

	logic [DIV_STAGES-1:0] v_q;
	div_lane_t             x_q [DIV_STAGES];
	div_lane_t             y_q [DIV_STAGES];
	info_t                 i_q [DIV_STAGES];
	div_lane_t             x_in [DIV_STAGES];
	div_lane_t             y_in [DIV_STAGES];
	info_t                 i_in [DIV_STAGES];
	logic [DIV_STAGES-1:0] v_in;

	// Stage inputs: first from the port, the rest from the stage before
	always_comb begin
		x_in[0] = in_x;
		y_in[0] = in_y;
		i_in[0] = in_info;
		v_in[0] = in_valid;
		for (int j = 1; j < DIV_STAGES; j++) begin
			x_in[j] = x_q[j-1];
			y_in[j] = y_q[j-1];
			i_in[j] = i_q[j-1];
			v_in[j] = v_q[j-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < DIV_STAGES; j++) begin
				x_q[j] <= div_step(x_in[j]);
				y_q[j] <= div_step(y_in[j]);
				i_q[j] <= i_in[j];
			end
		end
	end

	assign out_valid = v_q[DIV_STAGES-1];
	assign out_x     = x_q[DIV_STAGES-1];
	assign out_y     = y_q[DIV_STAGES-1];
	assign out_info  = i_q[DIV_STAGES-1];

endmodule

FILE: design/bps_front.sv
// Front end: accepts transactions, maps coordinates and builds work items.
module bps_front #(
	parameter int MAX_ROW_BYTES = 512,
	parameter int MAX_ROWS      = 512
) (
	input  logic           clk,
	input  logic           arst_n,
	input  bps_pkg::cfg_t  cfg,
	input  logic           start,
	input  logic           op,
	input  logic [8:0]     src_col,
	input  logic [8:0]     src_row,
	input  logic [11:0]    dst_col,
	input  logic [11:0]    dst_row,
	input  logic           channel,
	input  logic [7:0]     sample,
	input  logic           full,
	output logic           push,
	output bps_pkg::work_t work
);
	import bps_pkg::*;

	localparam logic [13:0] ROWS_L  = 14'(MAX_ROWS);
	localparam logic [13:0] BYTES_L = 14'(MAX_ROW_BYTES);

	logic       en;
	logic       chan2;
	logic       ch_eff;
	logic [9:0] wr_off;
	logic [12:0] pt_off;
	logic [22:0] prod_x, prod_y;
	div_lane_t  lx, ly;
	info_t      li;

	logic      v_s1;
	div_lane_t x_s1, y_s1;
	info_t     i_s1;

	logic      dv;
	div_lane_t dx, dy;
	info_t     di;

	assign en    = !full;
	assign chan2 = cfg.channels[1];
	assign ch_eff = chan2 ? channel : 1'b0;

	// Classify the transaction and form both numerators
	always_comb begin
		wr_off = chan2 ? {src_col, ch_eff} : {1'b0, src_col};
		pt_off = chan2 ? {dst_col, ch_eff} : {1'b0, dst_col};
		prod_x = 23'({dst_col, 1'b1}) * 23'(cfg.src_width);
		prod_y = 23'({dst_row, 1'b1}) * 23'(cfg.src_height);
		lx.nq  = {prod_x[21:0], 8'h00};
		lx.rem = '0;
		lx.den = {cfg.dst_width, 1'b0};
		ly.nq  = {prod_y[21:0], 8'h00};
		ly.rem = '0;
		ly.den = {cfg.dst_height, 1'b0};
		li.is_write = (op == OP_WRITE);
		li.pass = (13'(cfg.src_width) == cfg.dst_width) &&
			(13'(cfg.src_height) == cfg.dst_height);
		li.ch = ch_eff;
		li.sample = sample;
		if (op == OP_WRITE) begin
			li.row = 13'(src_row);
			li.off = 13'(wr_off);
		end else begin
			li.row = 13'(dst_row);
			li.off = pt_off;
		end
		li.ok = (14'(li.row) < ROWS_L) && (14'(li.off) < BYTES_L);
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1 <= lx;
			y_s1 <= ly;
			i_s1 <= li;
		end
	end

	bps_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s1),
		.in_x     (x_s1),
		.in_y     (y_s1),
		.in_info  (i_s1),
		.out_valid(dv),
		.out_x    (dx),
		.out_y    (dy),
		.out_info (di)
	);

	// Split quotients into base and fraction, clamp, and form tap offsets
	always_comb begin
		logic [NUM_W-1:0] tx, ty;
		logic             negx, negy;
		logic [21:0]      bx, by;
		logic [22:0]      by1;
		logic [9:0]       hix, shm1, swm1, x0, x1, y0, y1;
		logic [12:0]      xo0, xo1;
		tx   = dx.nq - NUM_W'(FRAC_HALF);
		ty   = dy.nq - NUM_W'(FRAC_HALF);
		negx = dx.nq < NUM_W'(FRAC_HALF);
		negy = dy.nq < NUM_W'(FRAC_HALF);
		bx   = tx[NUM_W-1:FRAC_BITS];
		by   = ty[NUM_W-1:FRAC_BITS];
		by1  = 23'(by) + 23'd1;
		hix  = (cfg.src_width >= 10'd2) ? cfg.src_width - 10'd2 : 10'd0;
		swm1 = cfg.src_width - 10'd1;
		shm1 = cfg.src_height - 10'd1;
		x0 = negx ? 10'd0 : ((bx > 22'(hix)) ? hix : bx[9:0]);
		x1 = ((x0 + 10'd1) > swm1) ? swm1 : x0 + 10'd1;
		y0 = negy ? 10'd0 : ((by > 22'(shm1)) ? shm1 : by[9:0]);
		y1 = negy ? 10'd0 : ((by1 > 23'(shm1)) ? shm1 : by1[9:0]);
		xo0 = chan2 ? 13'({x0, di.ch}) : 13'(x0);
		xo1 = chan2 ? 13'({x1, di.ch}) : 13'(x1);

		work.is_write = di.is_write;
		work.pass     = di.pass;
		work.sample   = di.sample;
		work.fx       = tx[FRAC_BITS-1:0];
		work.fy       = ty[FRAC_BITS-1:0];
		if (di.is_write || di.pass) begin
			work.row0   = di.row;
			work.row1   = di.row;
			work.off0   = di.off;
			work.off1   = di.off;
			work.tap_ok = {3'b000, di.ok};
		end else begin
			work.row0   = 13'(y0);
			work.row1   = 13'(y1);
			work.off0   = xo0;
			work.off1   = xo1;
			work.tap_ok[0] = (14'(y0) < ROWS_L) && (14'(xo0) < BYTES_L);
			work.tap_ok[1] = (14'(y0) < ROWS_L) && (14'(xo1) < BYTES_L);
			work.tap_ok[2] = (14'(y1) < ROWS_L) && (14'(xo0) < BYTES_L);
			work.tap_ok[3] = (14'(y1) < ROWS_L) && (14'(xo1) < BYTES_L);
		end
	end

	assign push = en && dv;

endmodule

FILE: design/bps_fifo.sv
// Short work queue between the front end and the back end.
module bps_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  bps_pkg::work_t din,
	input  logic           pop,
	output bps_pkg::work_t dout,
	output logic           empty,
	output logic           full
);
	import bps_pkg::*;

	work_t             mem_q [QDEPTH];
	logic [QPTR_W-1:0] wp_q, rp_q;
	logic [QCNT_W-1:0] cnt_q;

	assign empty = (cnt_q == '0);
	assign full  = (cnt_q == QCNT_W'(QDEPTH));
	assign dout  = mem_q[rp_q];

	// Pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + QPTR_W'(1);
			end
			if (pop) begin
				rp_q <= rp_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= din;
		end
	end

endmodule

FILE: design/bps_back.sv
// Back end: frame memory access, four-tap fetch and bilinear blend.
module bps_back #(
	parameter int MAX_ROW_BYTES = 512,
	parameter int MAX_ROWS      = 512
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           empty,
	input  bps_pkg::work_t head,
	output logic           pop,
	output logic           done,
	output logic [7:0]     pixel
);
	import bps_pkg::*;

	localparam int DEPTH = MAX_ROW_BYTES * MAX_ROWS;
	localparam int AW    = $clog2(DEPTH);

	logic        act_q;
	work_t       cur_q;
	logic [1:0]  tap_q;
	logic        last;
	logic [12:0] row_sel, off_sel;
	logic [AW-1:0] addr;
	logic        we;
	logic [7:0]  rdata, data1;

	logic       rv_s1, pass_s1, zero_s1;
	logic [1:0] tap_s1;
	logic [7:0] fx_s1, fy_s1;
	logic [7:0] a_q, c_q, top_q;

	logic       v_s2, pass_s2;
	logic [7:0] byte_s2, top_s2, bot_s2, fy_s2;

	// Issue sequencer: one memory access per cycle while a work item is active
	assign last = cur_q.is_write || cur_q.pass || (tap_q == 2'd3);
	assign pop  = !empty && (!act_q || last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
			tap_q <= '0;
		end else begin
			act_q <= pop || (act_q && !last);
			if (pop) begin
				tap_q <= '0;
			end else if (act_q) begin
				tap_q <= tap_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head;
		end
	end

	// Tap address
	assign row_sel = tap_q[1] ? cur_q.row1 : cur_q.row0;
	assign off_sel = tap_q[0] ? cur_q.off1 : cur_q.off0;
	assign addr = AW'(AW'(row_sel) * AW'(MAX_ROW_BYTES)) + AW'(off_sel);
	assign we   = act_q && cur_q.is_write && cur_q.tap_ok[0];

	bps_ram #(
		.WIDTH(8),
		.DEPTH(DEPTH)
	) u_frame (
		.clk  (clk),
		.we   (we),
		.addr (addr),
		.wdata(cur_q.sample),
		.rdata(rdata)
	);

	// Read return tags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rv_s1 <= 1'b0;
		end else begin
			rv_s1 <= act_q && !cur_q.is_write;
		end
	end

	always_ff @(posedge clk) begin
		tap_s1  <= tap_q;
		pass_s1 <= cur_q.pass;
		zero_s1 <= !cur_q.tap_ok[tap_q];
		fx_s1   <= cur_q.fx;
		fy_s1   <= cur_q.fy;
	end

	assign data1 = zero_s1 ? 8'h00 : rdata;

	// Horizontal blends as taps return
	always_ff @(posedge clk) begin
		if (rv_s1) begin
			case (tap_s1)
				2'd0: a_q <= data1;
				2'd1: top_q <= lerp8(a_q, data1, fx_s1);
				2'd2: c_q <= data1;
				2'd3: begin
					top_s2 <= top_q;
					bot_s2 <= lerp8(c_q, data1, fx_s1);
				end
				default: a_q <= data1;
			endcase
		end
		pass_s2 <= pass_s1;
		byte_s2 <= data1;
		fy_s2   <= fy_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			done <= 1'b0;
		end else begin
			v_s2 <= rv_s1 && (pass_s1 || (tap_s1 == 2'd3));
			done <= v_s2;
		end
	end

	// Vertical blend and result register
	always_ff @(posedge clk) begin
		pixel <= pass_s2 ? byte_s2 : lerp8(top_s2, bot_s2, fy_s2);
	end

endmodule

FILE: design/bps_checker.sv
// Port-level checker for the bilinear plane scaler, bound to the top level.
`include "bilinear_plane_scaler_top_assert.svh"

module bps_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        psel,
	input logic        penable,
	input logic        pwrite,
	input logic [4:0]  paddr,
	input logic [31:0] pwdata,
	input logic [31:0] prdata,
	input logic        pready,
	input logic        start,
	input logic        busy,
	input logic        op,
	input logic [8:0]  src_col,
	input logic [8:0]  src_row,
	input logic [11:0] dst_col,
	input logic [11:0] dst_row,
	input logic        channel,
	input logic [7:0]  sample,
	input logic        done,
	input logic [7:0]  pixel
);

	// Reset leaves no result and an open input
	`BPS_ASSERT_ALWAYS(a_reset_quiet, !arst_n |-> (!done && !busy), "activity during reset")
	// Register port never waits
	`BPS_ASSERT_ALWAYS(a_pready, pready, "pready low")
	// No result can appear before a transaction has crossed the pipeline
	`BPS_ASSERT_IMPL(a_done_latency, done, $past(arst_n, 30), "result too soon after reset")

endmodule

bind bilinear_plane_scaler_top bps_checker u_bps_checker (.*);
